// File: rtl/core/ebph_pkg.sv
package ebph_pkg;

    // Default number of entries in the queue between front and back.
    localparam int EBPH_QUEUE_DEPTH = 4;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_START_SEND = 2'd0,
        REQ_PAYLOAD    = 2'd1,
        REQ_START_RECV = 2'd2,
        REQ_LINE       = 2'd3
    } t_req;

    // Destination codes of a result word.
    localparam logic [1:0] DEST_TX   = 2'd0;
    localparam logic [1:0] DEST_HOST = 2'd1;
    localparam logic [1:0] DEST_DONE = 2'd2;

    // Command bytes; the low nibble carries the device number.
    localparam logic [7:0] CMD_SEND = 8'h60;
    localparam logic [7:0] CMD_RECV = 8'h40;
    localparam logic [7:0] CMD_CTS  = 8'h30;
    localparam logic [7:0] CMD_RESP = 8'hB0;
    localparam logic [7:0] CMD_NACK = 8'hC0;
    localparam logic [7:0] CMD_ACK  = 8'h20;

    // Up to four result words produced by one input word.
    typedef struct packed {
        logic [1:0]      dest;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        logic [15:0]     rx_length;
    } t_entry;

    // Write side of the queue.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_enq;

endpackage

// File: rtl/core/ebph_front.sv
module ebph_front import ebph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_dev,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_length,
    input  logic        i_q_full,
    output t_enq        o_enq
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_S_PAY, PH_S_ECHO_FIX, PH_S_ECHO_PAY, PH_S_STATUS,
        PH_R_ECHO, PH_R_RESP, PH_R_ECHO_CTS, PH_R_RESP2, PH_R_LEN_HI,
        PH_R_LEN_LO, PH_R_PAY, PH_R_CK, PH_R_STATUS
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_frame_length, n_frame_length;
    logic [7:0]  r_running_xor, n_running_xor;
    logic [3:0]  r_device_id, n_device_id;
    logic [7:0]  r_first_response, n_first_response;

    logic        accept;
    logic [15:0] count_inc;
    logic [7:0]  xor_next;
    logic [7:0]  dev_byte;
    logic [7:0]  cur_dev_byte;

    assign accept       = push && !i_q_full;
    assign count_inc    = r_byte_count + 16'd1;
    assign xor_next     = r_running_xor ^ i_data;
    assign dev_byte     = {4'h0, i_dev};
    assign cur_dev_byte = {4'h0, r_device_id};

    // Classify the word, update the protocol state and build the results.
    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_frame_length   = r_frame_length;
        n_running_xor    = r_running_xor;
        n_device_id      = r_device_id;
        n_first_response = r_first_response;
        o_enq            = '0;

        unique case (t_req'(i_req_type))
            REQ_START_SEND: begin
                n_device_id          = i_dev;
                n_frame_length       = i_length;
                n_byte_count         = '0;
                n_running_xor        = '0;
                o_enq.valid          = 1'b1;
                o_enq.entry.dest     = DEST_TX;
                o_enq.entry.bytes[0] = CMD_SEND | dev_byte;
                o_enq.entry.bytes[1] = i_length[15:8];
                o_enq.entry.bytes[2] = i_length[7:0];
                o_enq.entry.bytes[3] = 8'h00;
                if (i_length == 16'd0) begin
                    o_enq.entry.last_idx = 2'd3;
                    n_phase              = PH_S_ECHO_FIX;
                end else begin
                    o_enq.entry.last_idx = 2'd2;
                    n_phase              = PH_S_PAY;
                end
            end
            REQ_START_RECV: begin
                n_device_id          = i_dev;
                n_frame_length       = '0;
                n_byte_count         = '0;
                o_enq.valid          = 1'b1;
                o_enq.entry.dest     = DEST_TX;
                o_enq.entry.bytes[0] = CMD_RECV | dev_byte;
                n_phase              = PH_R_ECHO;
            end
            REQ_PAYLOAD: begin
                if (r_phase == PH_S_PAY) begin
                    n_running_xor        = xor_next;
                    o_enq.valid          = 1'b1;
                    o_enq.entry.dest     = DEST_TX;
                    o_enq.entry.bytes[0] = i_data;
                    if (count_inc == r_frame_length) begin
                        o_enq.entry.bytes[1] = xor_next;
                        o_enq.entry.last_idx = 2'd1;
                        n_byte_count         = '0;
                        n_phase              = PH_S_ECHO_FIX;
                    end else begin
                        n_byte_count = count_inc;
                    end
                end
            end
            REQ_LINE: begin
                unique case (r_phase)
                    PH_S_ECHO_FIX: begin
                        // Header, two length bytes and checksum echo back.
                        if (count_inc >= 16'd4) begin
                            n_byte_count = '0;
                            n_phase = (r_frame_length != 16'd0) ? PH_S_ECHO_PAY
                                                                : PH_S_STATUS;
                        end else begin
                            n_byte_count = count_inc;
                        end
                    end
                    PH_S_ECHO_PAY: begin
                        n_byte_count = count_inc;
                        if (count_inc == r_frame_length) begin
                            n_phase = PH_S_STATUS;
                        end
                    end
                    PH_S_STATUS: begin
                        o_enq.valid          = 1'b1;
                        o_enq.entry.dest     = DEST_DONE;
                        o_enq.entry.bytes[0] = i_data;
                        n_phase              = PH_IDLE;
                    end
                    PH_R_ECHO: begin
                        n_phase = PH_R_RESP;
                    end
                    PH_R_RESP: begin
                        n_first_response = i_data;
                        o_enq.valid      = 1'b1;
                        if (i_data == (CMD_NACK | cur_dev_byte)) begin
                            o_enq.entry.dest     = DEST_DONE;
                            o_enq.entry.bytes[0] = i_data;
                            n_phase              = PH_IDLE;
                        end else begin
                            o_enq.entry.dest     = DEST_TX;
                            o_enq.entry.bytes[0] = CMD_CTS | cur_dev_byte;
                            n_phase              = PH_R_ECHO_CTS;
                        end
                    end
                    PH_R_ECHO_CTS: begin
                        n_phase = PH_R_RESP2;
                    end
                    PH_R_RESP2: begin
                        if (i_data == (CMD_RESP | cur_dev_byte)) begin
                            n_phase = PH_R_LEN_HI;
                        end else begin
                            o_enq.valid          = 1'b1;
                            o_enq.entry.dest     = DEST_DONE;
                            o_enq.entry.bytes[0] = r_first_response;
                            n_phase              = PH_IDLE;
                        end
                    end
                    PH_R_LEN_HI: begin
                        n_frame_length = {i_data, 8'h00};
                        n_phase        = PH_R_LEN_LO;
                    end
                    PH_R_LEN_LO: begin
                        n_frame_length = {r_frame_length[15:8], i_data};
                        n_byte_count   = '0;
                        n_phase = ({r_frame_length[15:8], i_data} != 16'd0) ? PH_R_PAY
                                                                            : PH_R_CK;
                    end
                    PH_R_PAY: begin
                        o_enq.valid          = 1'b1;
                        o_enq.entry.dest     = DEST_HOST;
                        o_enq.entry.bytes[0] = i_data;
                        n_byte_count         = count_inc;
                        if (count_inc == r_frame_length) begin
                            n_phase = PH_R_CK;
                        end
                    end
                    PH_R_CK: begin
                        // The checksum byte is dropped without a check.
                        o_enq.valid          = 1'b1;
                        o_enq.entry.dest     = DEST_TX;
                        o_enq.entry.bytes[0] = CMD_ACK | cur_dev_byte;
                        n_phase              = PH_R_STATUS;
                    end
                    PH_R_STATUS: begin
                        o_enq.valid           = 1'b1;
                        o_enq.entry.dest      = DEST_DONE;
                        o_enq.entry.bytes[0]  = i_data;
                        o_enq.entry.rx_length = r_frame_length;
                        n_phase               = PH_IDLE;
                    end
                    default: begin
                        // Stray line bytes while idle or in the send payload.
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (!accept) begin
            o_enq.valid = 1'b0;
        end
    end

    // Protocol state, updated only on accepted words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_byte_count     <= '0;
            r_frame_length   <= '0;
            r_running_xor    <= '0;
            r_device_id      <= '0;
            r_first_response <= '0;
        end else if (accept) begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_frame_length   <= n_frame_length;
            r_running_xor    <= n_running_xor;
            r_device_id      <= n_device_id;
            r_first_response <= n_first_response;
        end
    end

endmodule

// File: rtl/core/ebph_queue.sv
module ebph_queue import ebph_pkg::*; #(
    parameter int DEPTH = EBPH_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_enq   i_enq,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_enq.valid && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_enq.entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/ebph_back.sv
module ebph_back import ebph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_entry      i_q_head,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_dest,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_rx_length,
    output logic        o_last
);

    logic       r_valid;
    t_entry     r_entry;
    logic [1:0] r_idx;
    logic       take, done, load;

    assign take    = r_valid && pop;
    assign done    = take && (r_idx == r_entry.last_idx);
    assign load    = (!r_valid || done) && !i_q_empty;
    assign o_q_pop = load;

    // Present the current word of the entry being unpacked.
    assign empty       = !r_valid;
    assign o_dest      = r_entry.dest;
    assign o_out_byte  = r_entry.bytes[r_idx];
    assign o_rx_length = r_entry.rx_length;
    assign o_last      = (r_idx == r_entry.last_idx);

    // Control: entry valid and word index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= i_q_head;
        end
    end

endmodule

// File: rtl/core/echo_bus_packet_host_engine.sv
// Channel  | Handshake        | Word fields
// ---------+------------------+---------------------------------------------
// request  | push / full      | i_req_type, i_dev, i_data, i_length
// result   | pop / empty      | o_dest, o_out_byte, o_rx_length, o_last
//
// The front takes one request word per cycle while full is low; full rises
// when the QUEUE_DEPTH-entry queue is full, and a word makes at most one entry.
// The back drains one result word per cycle while pop is high, so a four-word
// entry holds the queue head until its last word is taken, and pop stalls
// back up into full. A first result word is registered in the queue and then
// in the back. Reset is synchronous and active low; it returns to idle and drops results.
module echo_bus_packet_host_engine import ebph_pkg::*; #(
    parameter int QUEUE_DEPTH = EBPH_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_dev,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_length,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_dest,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_rx_length,
    output logic        o_last
);

    t_enq   enq;
    t_entry q_head;
    logic   q_full, q_empty, q_pop;

    assign full = q_full;

    // Request classification and protocol state.
    ebph_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_req_type (i_req_type),
        .i_dev      (i_dev),
        .i_data     (i_data),
        .i_length   (i_length),
        .i_q_full   (q_full),
        .o_enq      (enq)
    );

    // Entry queue between front and back.
    ebph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Result word sequencing.
    ebph_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_dest      (o_dest),
        .o_out_byte  (o_out_byte),
        .o_rx_length (o_rx_length),
        .o_last      (o_last)
    );

endmodule

// File: rtl/core/ebph_checker.sv
module ebph_checker import ebph_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_dest,
    input logic [7:0]  o_out_byte,
    input logic [15:0] o_rx_length,
    input logic        o_last
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset leaves room for a request.
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("request side full after reset");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_dest) && $stable(o_out_byte)
                              && $stable(o_rx_length) && $stable(o_last)))
        else $error("waiting result changed before it was taken");

    // Only a completion word can carry a received length.
    a_length_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rx_length != 16'd0) |-> (o_dest == DEST_DONE && o_last))
        else $error("received length on a word that is not a completion");

    // Completion words always close the words of their request.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_dest == DEST_DONE) |-> o_last)
        else $error("completion word not marked last");

endmodule

bind echo_bus_packet_host_engine ebph_checker u_ebph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_dest      (o_dest),
    .o_out_byte  (o_out_byte),
    .o_rx_length (o_rx_length),
    .o_last      (o_last)
);

// File: tb/ebph_link_monitor.sv
`timescale 1ns / 100ps

// Watches both channels of the packet engine. It keeps its own copy of the
// bus protocol state, predicts the result words of every accepted request
// word, and compares each accepted result word with the oldest prediction.
module ebph_link_monitor import ebph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_dev,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_length,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_dest,
    input  logic [7:0]  i_out_byte,
    input  logic [15:0] i_rx_length,
    input  logic        i_last,
    output int          o_mismatch_count,
    output int          o_words_owed
);

    // Protocol phases of the host side of the bus.
    typedef enum logic [3:0] {
        LINK_IDLE,
        LINK_SEND_PAYLOAD,
        LINK_SEND_ECHO_HDR,
        LINK_SEND_ECHO_PAYLOAD,
        LINK_SEND_STATUS,
        LINK_RECV_ECHO,
        LINK_RECV_RESP,
        LINK_RECV_ECHO_CTS,
        LINK_RECV_RESP2,
        LINK_RECV_LEN_HI,
        LINK_RECV_LEN_LO,
        LINK_RECV_PAYLOAD,
        LINK_RECV_CHECKSUM,
        LINK_RECV_STATUS
    } t_link_phase;

    typedef struct packed {
        logic [1:0]  dest;
        logic [7:0]  out_byte;
        logic [15:0] rx_length;
        logic        last;
    } t_link_word;

    t_link_phase link_phase;
    logic [15:0] byte_cnt;
    logic [15:0] frame_len;
    logic [7:0]  payload_xor;
    logic [3:0]  device_num;
    logic [7:0]  first_resp;
    int          words_made;
    t_link_word  expected_words[$];

    // Queue one predicted result word; the last flag is set afterwards.
    task automatic emit(input logic [1:0] dest, input logic [7:0] b,
                        input logic [15:0] rxl);
        t_link_word w;
        w = '{dest, b, rxl, 1'b0};
        expected_words.push_back(w);
        words_made++;
    endtask

    // Advance the protocol state by one request word and queue its results.
    task automatic predict_link_words(input t_req req, input logic [3:0] dv,
                                      input logic [7:0] d, input logic [15:0] len);
        t_link_word tail;
        words_made = 0;
        case (req)
            REQ_START_SEND: begin
                device_num  = dv;
                frame_len   = len;
                byte_cnt    = '0;
                payload_xor = '0;
                emit(DEST_TX, CMD_SEND | {4'h0, dv}, 16'h0);
                emit(DEST_TX, len[15:8], 16'h0);
                emit(DEST_TX, len[7:0], 16'h0);
                if (len == 16'h0) begin
                    // An empty frame carries a zero checksum right away.
                    emit(DEST_TX, 8'h00, 16'h0);
                    link_phase = LINK_SEND_ECHO_HDR;
                end else begin
                    link_phase = LINK_SEND_PAYLOAD;
                end
            end
            REQ_START_RECV: begin
                device_num = dv;
                frame_len  = '0;
                byte_cnt   = '0;
                emit(DEST_TX, CMD_RECV | {4'h0, dv}, 16'h0);
                link_phase = LINK_RECV_ECHO;
            end
            REQ_PAYLOAD: begin
                // Payload words outside the payload phase are dropped.
                if (link_phase == LINK_SEND_PAYLOAD) begin
                    payload_xor = payload_xor ^ d;
                    emit(DEST_TX, d, 16'h0);
                    byte_cnt = byte_cnt + 16'h1;
                    if (byte_cnt == frame_len) begin
                        emit(DEST_TX, payload_xor, 16'h0);
                        byte_cnt   = '0;
                        link_phase = LINK_SEND_ECHO_HDR;
                    end
                end
            end
            default: begin
                // A byte from the line; ignored while idle or owed payload.
                case (link_phase)
                    LINK_SEND_ECHO_HDR: begin
                        byte_cnt = byte_cnt + 16'h1;
                        if (byte_cnt >= 16'd4) begin
                            byte_cnt   = '0;
                            link_phase = (frame_len != 16'h0) ? LINK_SEND_ECHO_PAYLOAD
                                                              : LINK_SEND_STATUS;
                        end
                    end
                    LINK_SEND_ECHO_PAYLOAD: begin
                        byte_cnt = byte_cnt + 16'h1;
                        if (byte_cnt == frame_len) begin
                            link_phase = LINK_SEND_STATUS;
                        end
                    end
                    LINK_SEND_STATUS: begin
                        emit(DEST_DONE, d, 16'h0);
                        link_phase = LINK_IDLE;
                    end
                    LINK_RECV_ECHO: begin
                        link_phase = LINK_RECV_RESP;
                    end
                    LINK_RECV_RESP: begin
                        first_resp = d;
                        if (d == (CMD_NACK | {4'h0, device_num})) begin
                            emit(DEST_DONE, d, 16'h0);
                            link_phase = LINK_IDLE;
                        end else begin
                            emit(DEST_TX, CMD_CTS | {4'h0, device_num}, 16'h0);
                            link_phase = LINK_RECV_ECHO_CTS;
                        end
                    end
                    LINK_RECV_ECHO_CTS: begin
                        link_phase = LINK_RECV_RESP2;
                    end
                    LINK_RECV_RESP2: begin
                        if (d == (CMD_RESP | {4'h0, device_num})) begin
                            link_phase = LINK_RECV_LEN_HI;
                        end else begin
                            emit(DEST_DONE, first_resp, 16'h0);
                            link_phase = LINK_IDLE;
                        end
                    end
                    LINK_RECV_LEN_HI: begin
                        frame_len  = {d, 8'h00};
                        link_phase = LINK_RECV_LEN_LO;
                    end
                    LINK_RECV_LEN_LO: begin
                        frame_len  = frame_len | {8'h00, d};
                        byte_cnt   = '0;
                        link_phase = (frame_len != 16'h0) ? LINK_RECV_PAYLOAD
                                                          : LINK_RECV_CHECKSUM;
                    end
                    LINK_RECV_PAYLOAD: begin
                        emit(DEST_HOST, d, 16'h0);
                        byte_cnt = byte_cnt + 16'h1;
                        if (byte_cnt == frame_len) begin
                            link_phase = LINK_RECV_CHECKSUM;
                        end
                    end
                    LINK_RECV_CHECKSUM: begin
                        // The received checksum is not verified.
                        emit(DEST_TX, CMD_ACK | {4'h0, device_num}, 16'h0);
                        link_phase = LINK_RECV_STATUS;
                    end
                    LINK_RECV_STATUS: begin
                        emit(DEST_DONE, d, frame_len);
                        link_phase = LINK_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        if (words_made > 0) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    // Results are checked before the request of the same edge is predicted;
    // a request's first result cannot leave in the cycle it is accepted.
    always @(posedge i_clk) begin
        t_link_word actual;
        t_link_word wanted;
        if (!i_rst_n) begin
            link_phase  = LINK_IDLE;
            byte_cnt    = '0;
            frame_len   = '0;
            payload_xor = '0;
            device_num  = '0;
            first_resp  = '0;
            expected_words.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_pop && !i_empty) begin
                actual = '{i_dest, i_out_byte, i_rx_length, i_last};
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected: dest %0d byte %02h len %04h last %0d",
                             $time, i_dest, i_out_byte, i_rx_length, i_last);
                    o_mismatch_count++;
                end else begin
                    wanted = expected_words.pop_front();
                    if (actual != wanted) begin
                        $display("%0t: result word mismatch: expected dest %0d byte %02h len %04h last %0d, actual dest %0d byte %02h len %04h last %0d",
                                 $time, wanted.dest, wanted.out_byte, wanted.rx_length,
                                 wanted.last, i_dest, i_out_byte, i_rx_length, i_last);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_link_words(t_req'(i_req_type), i_dev, i_data, i_length);
            end
        end
        o_words_owed = expected_words.size();
    end

    initial begin
        o_mismatch_count = 0;
        o_words_owed     = 0;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ebph_pkg::*;

    localparam int ITEM_TARGET    = 360;
    localparam int IDLE_LIMIT     = 500;
    localparam int DRAIN_CYCLES   = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  req_type;
    logic [3:0]  dev;
    logic [7:0]  data;
    logic [15:0] length;
    logic        empty;
    logic        pop;
    logic [1:0]  dest;
    logic [7:0]  out_byte;
    logic [15:0] rx_length;
    logic        res_last;

    int mismatch_count;
    int words_owed;
    int items_sent;
    int seq_budget;
    int idle_cycles;
    bit send_burst;
    bit take_burst;

    echo_bus_packet_host_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req_type  (req_type),
        .i_dev       (dev),
        .i_data      (data),
        .i_length    (length),
        .empty       (empty),
        .pop         (pop),
        .o_dest      (dest),
        .o_out_byte  (out_byte),
        .o_rx_length (rx_length),
        .o_last      (res_last)
    );

    ebph_link_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_req_type       (req_type),
        .i_dev            (dev),
        .i_data           (data),
        .i_length         (length),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_dest           (dest),
        .i_out_byte       (out_byte),
        .i_rx_length      (rx_length),
        .i_last           (res_last),
        .o_mismatch_count (mismatch_count),
        .o_words_owed     (words_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive one request word after a random gap and hold it until accepted.
    // A sequence cut short simply stops driving once its budget runs out.
    task automatic put_word(input t_req req, input logic [3:0] dv, input logic [7:0] d,
                            input logic [15:0] len, input bit counted);
        int gap;
        if (seq_budget == 0) return;
        seq_budget--;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push     = 1'b1;
        req_type = req;
        dev      = dv;
        data     = d;
        length   = len;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        if (counted) items_sent++;
    endtask

    // Mostly short frames, now and then a longer one.
    function automatic logic [15:0] pick_length();
        if ($urandom_range(0, 15) == 0) return 16'($urandom_range(7, 40));
        return 16'($urandom_range(0, 6));
    endfunction

    // Send frame: header, payload, then the echoes and the status byte.
    // With noisy set, stray words that the engine must ignore are mixed in.
    task automatic run_send(input logic [3:0] dv, input logic [15:0] len, input bit noisy);
        put_word(REQ_START_SEND, dv, 8'($urandom), len, 1'b1);
        for (int k = 0; k < int'(len); k++) begin
            if (noisy && $urandom_range(0, 3) == 0)
                put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b0);
            put_word(REQ_PAYLOAD, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
        end
        for (int k = 0; k < int'(len) + 4; k++) begin
            if (noisy && $urandom_range(0, 3) == 0)
                put_word(REQ_PAYLOAD, 4'($urandom), 8'($urandom), 16'($urandom), 1'b0);
            put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
        end
        put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    endtask

    // Receive exchange as the device would answer it, with occasional NACKs
    // and wrong responses.
    task automatic run_recv(input logic [3:0] dv);
        logic [7:0]  resp;
        logic [15:0] plen;
        put_word(REQ_START_RECV, dv, 8'($urandom), 16'($urandom), 1'b1);
        put_word(REQ_LINE, 4'($urandom), CMD_RECV | {4'h0, dv}, 16'($urandom), 1'b1);
        if ($urandom_range(0, 5) == 0) begin
            put_word(REQ_LINE, 4'($urandom), CMD_NACK | {4'h0, dv}, 16'($urandom), 1'b1);
            return;
        end
        resp = 8'($urandom);
        put_word(REQ_LINE, 4'($urandom), resp, 16'($urandom), 1'b1);
        if (resp == (CMD_NACK | {4'h0, dv})) return;
        put_word(REQ_LINE, 4'($urandom), CMD_CTS | {4'h0, dv}, 16'($urandom), 1'b1);
        resp = ($urandom_range(0, 4) == 0) ? 8'($urandom) : (CMD_RESP | {4'h0, dv});
        put_word(REQ_LINE, 4'($urandom), resp, 16'($urandom), 1'b1);
        if (resp != (CMD_RESP | {4'h0, dv})) return;
        plen = pick_length();
        put_word(REQ_LINE, 4'($urandom), plen[15:8], 16'($urandom), 1'b1);
        put_word(REQ_LINE, 4'($urandom), plen[7:0], 16'($urandom), 1'b1);
        for (int k = 0; k < int'(plen); k++)
            put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
        put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
        put_word(REQ_LINE, 4'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    endtask

    // Result side: random stalls before each word, with stretches of none.
    initial begin
        int stall;
        pop = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Watchdog: ends the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        req_type    = REQ_START_SEND;
        dev         = '0;
        data        = '0;
        length      = '0;
        items_sent  = 0;
        idle_cycles = 0;
        seq_budget  = 32'h7fff_ffff;
        send_burst  = 1'b0;
        take_burst  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Stray line byte and stray payload byte while idle.
        put_word(REQ_LINE, 4'h0, 8'hFF, 16'hFFFF, 1'b0);
        put_word(REQ_PAYLOAD, 4'hF, 8'h00, 16'h0000, 1'b0);
        // Empty frame: checksum goes out with the header, four echoes.
        run_send(4'hF, 16'h0000, 1'b0);
        // Longest frame, a line byte while payload is owed, then abandoned.
        put_word(REQ_START_SEND, 4'hA, 8'h00, 16'hFFFF, 1'b1);
        put_word(REQ_LINE, 4'h5, 8'hA5, 16'h0000, 1'b0);
        put_word(REQ_PAYLOAD, 4'h0, 8'hFF, 16'hFFFF, 1'b1);
        // Receive start cuts the send short; the device answers with NACK.
        put_word(REQ_START_RECV, 4'h5, 8'h00, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_RECV | 8'h05, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_NACK | 8'h05, 16'h0000, 1'b1);
        // Some other response, then a wrong second response.
        put_word(REQ_START_RECV, 4'h3, 8'hFF, 16'hFFFF, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_RECV | 8'h03, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h12, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_CTS | 8'h03, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h00, 16'h0000, 1'b1);
        // Full receive of an empty frame.
        put_word(REQ_START_RECV, 4'h0, 8'h00, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_RECV, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h00, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_CTS, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, CMD_RESP, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h00, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h00, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'hFF, 16'h0000, 1'b1);
        put_word(REQ_LINE, 4'h0, 8'h7E, 16'h0000, 1'b1);

        // Random traffic: mostly complete exchanges, some cut short by the
        // next start, plus loose words of any kind.
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            seq_budget = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 32'h7fff_ffff;
            if (pick < 4) begin
                run_send(4'($urandom), pick_length(), $urandom_range(0, 3) == 0);
            end else if (pick < 8) begin
                run_recv(4'($urandom));
            end else begin
                repeat ($urandom_range(1, 3))
                    put_word(t_req'(2'($urandom)), 4'($urandom), 8'($urandom),
                             16'($urandom), 1'b0);
            end
            seq_budget = 32'h7fff_ffff;
        end
        push = 1'b0;

        // Let every predicted word drain, then wait out the drain period.
        while (words_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
